// ===== hdl/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and constants for the fixed-point quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OPND_W     = DATA_WIDTH + 1;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int RND_W      = PROD_W - FRAC_BITS;
   localparam int SUM_W      = RND_W + 3;
   localparam int NUM_PROD   = 16;
   localparam int NUM_RES    = 9;
   localparam int NUM_IN     = 9;
   localparam int OP_W       = 3;
   localparam int TDATA_W    = ((NUM_IN * DATA_WIDTH + 7) / 8) * 8;
   localparam int RDATA_W    = ((NUM_RES * DATA_WIDTH + 7) / 8) * 8;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [OPND_W-1:0]     opnd_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [RND_W-1:0]      rnd_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   typedef enum logic [OP_W-1:0] {
      OP_MUL  = 3'd0,
      OP_ADD  = 3'd1,
      OP_CONJ = 3'd2,
      OP_DOT  = 3'd3,
      OP_LERP = 3'd4,
      OP_ROT  = 3'd5
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } ctl_type;

   localparam opnd_type ONE_OPND  = opnd_type'(longint'(1) <<< FRAC_BITS);
   localparam opnd_type MONE_OPND = opnd_type'(-(longint'(1) <<< FRAC_BITS));
   localparam prod_type RND_HALF  = prod_type'(longint'(1) <<< (FRAC_BITS - 1));
   localparam sum_type  ONE_SUM   = sum_type'(longint'(1) <<< FRAC_BITS);
   localparam sum_type  SAT_MAX   = sum_type'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
   localparam sum_type  SAT_MIN   = sum_type'(-(longint'(1) <<< (DATA_WIDTH - 1)));

endpackage

// ===== hdl/quaternion_arithmetic_unit_core.sv =====
// An accepted req beat is registered in every stage below before rsp_tvalid rises.
// Throughput: one beat per cycle while rsp_tready is high; four register stages
// (operand select, multiply, round, combine/saturate), each held while the next is full.
// Reset: synchronous, active high; clears the stage control registers (valid and op) only.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Q2.14 quaternion ALU: product, sum, conjugate, dot, lerp, rotation matrix.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend
   input  logic [qau_pkg::TDATA_W-1:0]     req_tdata,
   // op
   input  logic [qau_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // r0, r1, r2, r3, m11, m12, m20, m21, m22
   output logic [qau_pkg::RDATA_W-1:0]     rsp_tdata,
   // overflow
   output logic                            rsp_tuser
);
   import qau_pkg::*;

   data_type a [4];
   data_type b [4];
   data_type blend;
   ctl_type  sel_ctl;
   ctl_type  mul_ctl;
   ctl_type  rnd_ctl;
   ctl_type  out_ctl;
   opnd_type x [NUM_PROD];
   opnd_type y [NUM_PROD];
   rnd_type  rnd [NUM_PROD];
   data_type res [NUM_RES];
   logic     ovf;
   logic     load_sel;
   logic     load_mul;
   logic     load_rnd;
   logic     load_out;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a[k] = data_type'(req_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
         b[k] = data_type'(req_tdata[(k+4)*DATA_WIDTH +: DATA_WIDTH]);
      end
      blend = data_type'(req_tdata[8*DATA_WIDTH +: DATA_WIDTH]);
   end

   assign load_out   = !out_ctl.valid || rsp_tready;
   assign load_rnd   = !rnd_ctl.valid || load_out;
   assign load_mul   = !mul_ctl.valid || load_rnd;
   assign load_sel   = !sel_ctl.valid || load_mul;
   assign req_tready = load_sel;

   qau_operand_select u_select (
      .clock    (clock),
      .reset    (reset),
      .load     (load_sel),
      .in_valid (req_tvalid),
      .in_op    (req_tuser),
      .a        (a),
      .b        (b),
      .blend    (blend),
      .ctl_ff   (sel_ctl),
      .x_ff     (x),
      .y_ff     (y)
   );

   qau_multiply u_multiply (
      .clock      (clock),
      .reset      (reset),
      .load_mul   (load_mul),
      .load_rnd   (load_rnd),
      .in_ctl     (sel_ctl),
      .x          (x),
      .y          (y),
      .mul_ctl_ff (mul_ctl),
      .rnd_ctl_ff (rnd_ctl),
      .rnd_ff     (rnd)
   );

   qau_combine u_combine (
      .clock  (clock),
      .reset  (reset),
      .load   (load_out),
      .in_ctl (rnd_ctl),
      .rnd    (rnd),
      .ctl_ff (out_ctl),
      .res_ff (res),
      .ovf_ff (ovf)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NUM_RES; i++) begin
         rsp_tdata[i*DATA_WIDTH +: DATA_WIDTH] = res[i];
      end
   end

   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tuser  = ovf;

endmodule

// ===== hdl/qau_operand_select.sv =====
// ----------------------------------------------------------------------------
// qau_operand_select
// First stage: maps each opcode onto sixteen multiplier operand pairs.
// ----------------------------------------------------------------------------
module qau_operand_select (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      in_valid,
   input  logic [qau_pkg::OP_W-1:0]  in_op,
   input  qau_pkg::data_type         a [4],
   input  qau_pkg::data_type         b [4],
   input  qau_pkg::data_type         blend,
   output qau_pkg::ctl_type          ctl_ff,
   output qau_pkg::opnd_type         x_ff [qau_pkg::NUM_PROD],
   output qau_pkg::opnd_type         y_ff [qau_pkg::NUM_PROD]
);
   import qau_pkg::*;

   opnd_type ae [4];
   opnd_type be [4];
   opnd_type t_opnd;
   opnd_type u_opnd;
   opnd_type x_in [NUM_PROD];
   opnd_type y_in [NUM_PROD];
   op_type   op;

   always_comb begin
      op     = op_type'(in_op);
      t_opnd = opnd_type'(blend);
      u_opnd = ONE_OPND - t_opnd;
      for (int k = 0; k < 4; k++) begin
         ae[k] = opnd_type'(a[k]);
         be[k] = opnd_type'(b[k]);
      end
      for (int i = 0; i < NUM_PROD; i++) begin
         x_in[i] = '0;
         y_in[i] = '0;
      end
      unique case (op)
         OP_MUL: begin
            x_in[0]  = ae[0]; y_in[0]  = be[0];
            x_in[1]  = ae[1]; y_in[1]  = be[1];
            x_in[2]  = ae[2]; y_in[2]  = be[2];
            x_in[3]  = ae[3]; y_in[3]  = be[3];
            x_in[4]  = ae[0]; y_in[4]  = be[1];
            x_in[5]  = be[0]; y_in[5]  = ae[1];
            x_in[6]  = ae[2]; y_in[6]  = be[3];
            x_in[7]  = ae[3]; y_in[7]  = be[2];
            x_in[8]  = ae[0]; y_in[8]  = be[2];
            x_in[9]  = be[0]; y_in[9]  = ae[2];
            x_in[10] = ae[3]; y_in[10] = be[1];
            x_in[11] = ae[1]; y_in[11] = be[3];
            x_in[12] = ae[0]; y_in[12] = be[3];
            x_in[13] = be[0]; y_in[13] = ae[3];
            x_in[14] = ae[1]; y_in[14] = be[2];
            x_in[15] = ae[2]; y_in[15] = be[1];
         end
         OP_ADD: begin
            for (int k = 0; k < 4; k++) begin
               x_in[4*k]   = ae[k]; y_in[4*k]   = ONE_OPND;
               x_in[4*k+1] = be[k]; y_in[4*k+1] = ONE_OPND;
            end
         end
         OP_CONJ: begin
            for (int k = 0; k < 4; k++) begin
               x_in[4*k] = ae[k];
               y_in[4*k] = (k == 0) ? ONE_OPND : MONE_OPND;
            end
         end
         OP_DOT: begin
            for (int k = 0; k < 4; k++) begin
               x_in[k] = ae[k]; y_in[k] = be[k];
            end
         end
         OP_LERP: begin
            for (int k = 0; k < 4; k++) begin
               x_in[4*k]   = ae[k]; y_in[4*k]   = u_opnd;
               x_in[4*k+1] = be[k]; y_in[4*k+1] = t_opnd;
            end
         end
         OP_ROT: begin
            // xx yy zz xy zw xz yw xw yz
            x_in[0] = ae[1]; y_in[0] = ae[1];
            x_in[1] = ae[2]; y_in[1] = ae[2];
            x_in[2] = ae[3]; y_in[2] = ae[3];
            x_in[3] = ae[1]; y_in[3] = ae[2];
            x_in[4] = ae[3]; y_in[4] = ae[0];
            x_in[5] = ae[1]; y_in[5] = ae[3];
            x_in[6] = ae[2]; y_in[6] = ae[0];
            x_in[7] = ae[1]; y_in[7] = ae[0];
            x_in[8] = ae[2]; y_in[8] = ae[3];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff.valid <= in_valid;
         ctl_ff.op    <= op;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_PROD; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
         end
      end
   end

endmodule

// ===== hdl/qau_multiply.sv =====
// ----------------------------------------------------------------------------
// qau_multiply
// Two stages: sixteen exact products, then round to nearest at FRAC_BITS.
// ----------------------------------------------------------------------------
module qau_multiply (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_mul,
   input  logic                load_rnd,
   input  qau_pkg::ctl_type    in_ctl,
   input  qau_pkg::opnd_type   x [qau_pkg::NUM_PROD],
   input  qau_pkg::opnd_type   y [qau_pkg::NUM_PROD],
   output qau_pkg::ctl_type    mul_ctl_ff,
   output qau_pkg::ctl_type    rnd_ctl_ff,
   output qau_pkg::rnd_type    rnd_ff [qau_pkg::NUM_PROD]
);
   import qau_pkg::*;

   prod_type prod_in [NUM_PROD];
   prod_type prod_ff [NUM_PROD];
   prod_type bias    [NUM_PROD];
   rnd_type  rnd_in  [NUM_PROD];

   always_comb begin
      for (int i = 0; i < NUM_PROD; i++) begin
         prod_in[i] = prod_type'(x[i]) * prod_type'(y[i]);
         bias[i]    = prod_ff[i] + RND_HALF;
         rnd_in[i]  = rnd_type'(bias[i] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         rnd_ctl_ff <= '0;
      end else begin
         if (load_mul) begin
            mul_ctl_ff <= in_ctl;
         end
         if (load_rnd) begin
            rnd_ctl_ff <= mul_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PROD; i++) begin
         if (load_mul) begin
            prod_ff[i] <= prod_in[i];
         end
         if (load_rnd) begin
            rnd_ff[i] <= rnd_in[i];
         end
      end
   end

endmodule

// ===== hdl/qau_combine.sv =====
// ----------------------------------------------------------------------------
// qau_combine
// Last stage: signed sums of rounded products, matrix terms, saturation.
// ----------------------------------------------------------------------------
module qau_combine (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  qau_pkg::ctl_type    in_ctl,
   input  qau_pkg::rnd_type    rnd [qau_pkg::NUM_PROD],
   output qau_pkg::ctl_type    ctl_ff,
   output qau_pkg::data_type   res_ff [qau_pkg::NUM_RES],
   output logic                ovf_ff
);
   import qau_pkg::*;

   sum_type  p      [NUM_PROD];
   sum_type  q      [4];
   sum_type  mat    [NUM_RES];
   sum_type  pick   [NUM_RES];
   data_type res_in [NUM_RES];
   logic     ovf_in;

   always_comb begin
      for (int i = 0; i < NUM_PROD; i++) begin
         p[i] = sum_type'(rnd[i]);
      end
      for (int k = 0; k < 4; k++) begin
         if (in_ctl.op == OP_MUL) begin
            if (k == 0) begin
               q[k] = p[0] - p[1] - p[2] - p[3];
            end else begin
               q[k] = p[4*k] + p[4*k+1] + p[4*k+2] - p[4*k+3];
            end
         end else begin
            q[k] = p[4*k] + p[4*k+1] + p[4*k+2] + p[4*k+3];
         end
      end
      // p0..p8: xx yy zz xy zw xz yw xw yz
      mat[0] = ONE_SUM - ((p[1] + p[2]) <<< 1);
      mat[1] = (p[3] - p[4]) <<< 1;
      mat[2] = (p[5] + p[6]) <<< 1;
      mat[3] = (p[3] + p[4]) <<< 1;
      mat[4] = ONE_SUM - ((p[0] + p[2]) <<< 1);
      mat[5] = (p[8] - p[7]) <<< 1;
      mat[6] = (p[5] - p[6]) <<< 1;
      mat[7] = (p[8] + p[7]) <<< 1;
      mat[8] = ONE_SUM - ((p[0] + p[1]) <<< 1);

      for (int i = 0; i < NUM_RES; i++) begin
         pick[i] = '0;
      end
      unique case (in_ctl.op)
         OP_MUL, OP_ADD, OP_CONJ, OP_DOT, OP_LERP: begin
            for (int k = 0; k < 4; k++) begin
               pick[k] = q[k];
            end
         end
         OP_ROT: begin
            for (int i = 0; i < NUM_RES; i++) begin
               pick[i] = mat[i];
            end
         end
         default: begin
         end
      endcase

      ovf_in = 1'b0;
      for (int i = 0; i < NUM_RES; i++) begin
         if (pick[i] > SAT_MAX) begin
            res_in[i] = data_type'(SAT_MAX);
            ovf_in    = 1'b1;
         end else if (pick[i] < SAT_MIN) begin
            res_in[i] = data_type'(SAT_MIN);
            ovf_in    = 1'b1;
         end else begin
            res_in[i] = data_type'(pick[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_RES; i++) begin
            res_ff[i] <= res_in[i];
         end
         ovf_ff <= ovf_in;
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the Q2.14 quaternion ALU core. A local model predicts
// every result beat from the req beat; each rsp beat is checked field by field
// against the oldest prediction while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import qau_pkg::*;

   localparam data_type Q_ONE = data_type'(1 <<< FRAC_BITS);
   localparam data_type Q_MAX = data_type'((1 <<< (DATA_WIDTH - 1)) - 1);
   localparam data_type Q_MIN = data_type'(-(1 <<< (DATA_WIDTH - 1)));

   typedef struct packed {
      logic               overflow;
      logic [RDATA_W-1:0] fields;
   } quat_result_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]    req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RDATA_W-1:0] rsp_tdata;
   logic               rsp_tuser;

   quat_result_type pending_results[$];
   int              error_count = 0;
   bit              steady_flow = 1'b0;
   string           rsp_names [NUM_RES] = '{"r0", "r1", "r2", "r3", "m11", "m12", "m20",
                                            "m21", "m22"};

   quaternion_arithmetic_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint operand(logic [TDATA_W-1:0] word, int idx);
      return longint'($signed(word[idx*DATA_WIDTH +: DATA_WIDTH]));
   endfunction

   // product rounded to nearest, ties toward +inf
   function automatic longint round_mul(longint x, longint y);
      return (x * y + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic quat_result_type quat_predict(logic [OP_W-1:0] op,
                                                    logic [TDATA_W-1:0] word);
      longint          aw, ax, ay, az, bw, bx, by, bz, t, u, one, hi, lo;
      longint          xx, yy, zz, xy, zw, xz, yw, xw, yz;
      longint          r [NUM_RES];
      quat_result_type res;
      aw  = operand(word, 0);
      ax  = operand(word, 1);
      ay  = operand(word, 2);
      az  = operand(word, 3);
      bw  = operand(word, 4);
      bx  = operand(word, 5);
      by  = operand(word, 6);
      bz  = operand(word, 7);
      t   = operand(word, 8);
      one = longint'(1) <<< FRAC_BITS;
      hi  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo  = -hi - 1;
      res = '0;
      for (int i = 0; i < NUM_RES; i++) r[i] = 0;
      case (op_type'(op))
         OP_MUL: begin
            r[0] = round_mul(aw, bw) - round_mul(ax, bx) - round_mul(ay, by) - round_mul(az, bz);
            r[1] = round_mul(aw, bx) + round_mul(bw, ax) + round_mul(ay, bz) - round_mul(az, by);
            r[2] = round_mul(aw, by) + round_mul(bw, ay) + round_mul(az, bx) - round_mul(ax, bz);
            r[3] = round_mul(aw, bz) + round_mul(bw, az) + round_mul(ax, by) - round_mul(ay, bx);
         end
         OP_ADD: begin
            r[0] = aw + bw;
            r[1] = ax + bx;
            r[2] = ay + by;
            r[3] = az + bz;
         end
         OP_CONJ: begin
            r[0] = aw;
            r[1] = -ax;
            r[2] = -ay;
            r[3] = -az;
         end
         OP_DOT: begin
            r[0] = round_mul(aw, bw) + round_mul(ax, bx) + round_mul(ay, by) + round_mul(az, bz);
         end
         OP_LERP: begin
            u    = one - t;
            r[0] = round_mul(aw, u) + round_mul(bw, t);
            r[1] = round_mul(ax, u) + round_mul(bx, t);
            r[2] = round_mul(ay, u) + round_mul(by, t);
            r[3] = round_mul(az, u) + round_mul(bz, t);
         end
         OP_ROT: begin
            xx   = round_mul(ax, ax);
            yy   = round_mul(ay, ay);
            zz   = round_mul(az, az);
            xy   = round_mul(ax, ay);
            zw   = round_mul(az, aw);
            xz   = round_mul(ax, az);
            yw   = round_mul(ay, aw);
            xw   = round_mul(ax, aw);
            yz   = round_mul(ay, az);
            r[0] = one - 2 * (yy + zz);
            r[1] = 2 * (xy - zw);
            r[2] = 2 * (xz + yw);
            r[3] = 2 * (xy + zw);
            r[4] = one - 2 * (xx + zz);
            r[5] = 2 * (yz - xw);
            r[6] = 2 * (xz - yw);
            r[7] = 2 * (yz + xw);
            r[8] = one - 2 * (xx + yy);
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_RES; i++) begin
         if (r[i] > hi) begin
            r[i]         = hi;
            res.overflow = 1'b1;
         end else if (r[i] < lo) begin
            r[i]         = lo;
            res.overflow = 1'b1;
         end
         res.fields[i*DATA_WIDTH +: DATA_WIDTH] = data_type'(r[i]);
      end
      return res;
   endfunction

   function automatic logic [TDATA_W-1:0] make_word(data_type aw, data_type ax, data_type ay,
                                                    data_type az, data_type bw, data_type bx,
                                                    data_type by, data_type bz, data_type t);
      return {t, bz, by, bx, bw, az, ay, ax, aw};
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic data_type rand_value(bit unit_range);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return data_type'(0);
            3: return Q_ONE;
            4: return -Q_ONE;
            default: return data_type'(1);
         endcase
      end
      if (unit_range) return data_type'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      return data_type'($urandom);
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      if ($urandom_range(0, 99) < 6) return OP_W'($urandom_range(6, 7));
      return OP_W'($urandom_range(0, 5));
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [TDATA_W-1:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(quat_predict(op, word));
   endtask

   task automatic test_extremes();
      for (int op = 0; op < 8; op++) begin
         send_item(OP_W'(op), {NUM_IN{Q_MAX}});
         send_item(OP_W'(op), {NUM_IN{Q_MIN}});
      end
   endtask

   task automatic test_special_cases();
      // negating the most negative value saturates
      send_item(OP_CONJ, make_word(Q_MIN, Q_MIN, 16'sd5, -16'sd7, 0, 0, 0, 0, 0));
      send_item(OP_MUL, make_word(Q_ONE, 0, 0, 0, 16'sd1000, -16'sd2000, 16'sd3000,
                                  -16'sd4000, 0));
      send_item(OP_ROT, make_word(Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(OP_LERP, make_word(16'sd1234, -16'sd99, Q_MAX, Q_MIN, -16'sd500, 16'sd77,
                                   Q_MIN, Q_MAX, 0));
      send_item(OP_LERP, make_word(16'sd1234, -16'sd99, Q_MAX, Q_MIN, -16'sd500, 16'sd77,
                                   Q_MIN, Q_MAX, Q_ONE));
      send_item(OP_LERP, make_word(Q_MAX, Q_MAX, Q_MIN, 0, Q_MIN, Q_MIN, Q_MAX, 0, Q_MIN));
      // rounding ties, positive and negative
      send_item(OP_MUL, make_word(16'sd1, 0, 0, 0, 16'sd8192, 0, 0, 0, 0));
      send_item(OP_DOT, make_word(-16'sd1, 0, 0, 0, 16'sd8192, 0, 0, 0, 0));
      send_item(OP_W'(6), make_word(Q_MAX, Q_MIN, Q_ONE, 1, 2, 3, 4, 5, 6));
   endtask

   task automatic test_random_mix(input int count);
      logic [TDATA_W-1:0] word;
      logic [OP_W-1:0]    op;
      for (int k = 0; k < count; k++) begin
         if (k % 150 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         op = rand_op();
         for (int i = 0; i < NUM_IN; i++) word[i*DATA_WIDTH +: DATA_WIDTH] = rand_value(1'b0);
         if (op == OP_LERP && $urandom_range(0, 1))
            word[8*DATA_WIDTH +: DATA_WIDTH] = data_type'($urandom_range(0, Q_ONE));
         send_item(op, word);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_unit_range(input int count);
      logic [TDATA_W-1:0] word;
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < NUM_IN; i++) word[i*DATA_WIDTH +: DATA_WIDTH] = rand_value(1'b1);
         word[8*DATA_WIDTH +: DATA_WIDTH] = data_type'($urandom_range(0, Q_ONE));
         send_item(OP_W'($urandom_range(0, 5)), word);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      quat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("rsp beat with no pending result");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < NUM_RES; i++) begin
               if (rsp_tdata[i*DATA_WIDTH +: DATA_WIDTH] !== want.fields[i*DATA_WIDTH +: DATA_WIDTH])
               begin
                  $error("%s expected %0d actual %0d", rsp_names[i],
                         $signed(want.fields[i*DATA_WIDTH +: DATA_WIDTH]),
                         $signed(rsp_tdata[i*DATA_WIDTH +: DATA_WIDTH]));
                  error_count++;
               end
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow expected %0d actual %0d", want.overflow, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_special_cases();
      test_random_mix(1200);
      test_unit_range(500);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
